### src/mbi_pkg.sv
package mbi_pkg;

	localparam int ROW_POINTS = 20;
	localparam int COL_POINTS = 20;
	localparam int MAX_POINTS = (ROW_POINTS > COL_POINTS) ? ROW_POINTS : COL_POINTS;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int MAP_DEPTH  = ROW_POINTS * COL_POINTS;
	localparam int MAP_AW     = $clog2(MAP_DEPTH);

	localparam int ROW_W  = 18;
	localparam int COL_W  = 15;
	localparam int OUT_W  = 16;
	localparam int RD_W   = ROW_W + 1;           // signed row weight
	localparam int CD_W   = COL_W + 1;           // signed column weight
	localparam int PROD_W = RD_W + CD_W;
	localparam int ACC_W  = PROD_W + OUT_W + 2;
	localparam int DEN_W  = ROW_W + COL_W;
	localparam int Q_W    = OUT_W + 2;           // quotient bits incl. overflow bit
	localparam int DSH_W  = DEN_W + 1 + Q_W - 1;
	localparam int REM_W  = ACC_W + 2;
	localparam int STEP_W = $clog2(Q_W);

	localparam logic [ROW_W-1:0] ROW_BP [ROW_POINTS] = '{
		18'd21600, 18'd32516, 18'd43432, 18'd54347, 18'd65263, 18'd76179, 18'd87095,
		18'd98011, 18'd108926, 18'd119842, 18'd130758, 18'd141674, 18'd152589,
		18'd163505, 18'd174421, 18'd185337, 18'd196253, 18'd207168, 18'd218084,
		18'd229000};

	localparam logic [COL_W-1:0] COL_BP [COL_POINTS] = '{
		15'd3200, 15'd4379, 15'd5558, 15'd6737, 15'd7916, 15'd9095, 15'd10274,
		15'd11453, 15'd12632, 15'd13811, 15'd14989, 15'd16168, 15'd17347, 15'd18526,
		15'd19705, 15'd20884, 15'd22063, 15'd23242, 15'd24421, 15'd25600};

	// ignition offset, Q8.8, row major
	localparam logic signed [OUT_W-1:0] OFFSET_MAP [MAP_DEPTH] = '{
		0, 0, 0, 0, -15, -151, -5197, -5197, -5197, -5197,
		-5197, -5197, -5197, -5197, -5197, -5197, -5197, -5197, -5197, -5197,
		0, 0, 0, 0, -3, -207, -1082, -3069, -2949, -5197,
		-5197, -5197, -5197, -5197, -5197, -5197, -5197, -5197, -5197, -5197,
		0, 0, 0, 0, -83, -573, -1267, -2246, -3098, -3560,
		-3983, -4376, -4002, -5197, -5197, -5197, -5197, -5197, -5197, -5197,
		0, 0, 0, 0, -113, -887, -1386, -1978, -2627, -3104,
		-3574, -4008, -4434, -4831, -5047, -5180, -5197, -5197, -5197, -5197,
		0, 0, 0, 0, -22, -427, -925, -1454, -2190, -2785,
		-3225, -3733, -4071, -4442, -4706, -4921, -5045, -5197, -5197, -5197,
		0, 0, 0, 0, 0, -148, -335, -692, -1606, -2367,
		-2841, -3334, -3687, -4068, -4338, -4560, -4759, -5063, -5197, -5197,
		0, 0, 0, 0, 0, -10, -87, -262, -1008, -1789,
		-2316, -2806, -3234, -3553, -3940, -4146, -4621, -4929, -5197, -5197,
		0, 0, 0, 0, 0, -15, -26, -151, -590, -1340,
		-1875, -2378, -2883, -3224, -3536, -3813, -4487, -4795, -5197, -5197,
		0, 0, 0, 0, 0, 0, -17, -81, -396, -1025,
		-1683, -2234, -2678, -3015, -3362, -3709, -4333, -4661, -5197, -5197,
		0, 0, 0, 0, -6, -1, -5, -110, -416, -1008,
		-1598, -2157, -2588, -2973, -3328, -3675, -4163, -4527, -5197, -5197,
		0, 0, 0, 0, -12, 0, -18, -158, -529, -1280,
		-1760, -2220, -2618, -3015, -3404, -3704, -4031, -4394, -4710, -5197,
		0, 0, 0, 0, -4, -17, -1, -153, -492, -1098,
		-1714, -2263, -2692, -3106, -3491, -3737, -3942, -4260, -4575, -5197,
		0, 0, -7, -3, 0, -7, -7, -103, -403, -1072,
		-1626, -2116, -2559, -2926, -3357, -3601, -3916, -4126, -4441, -5197,
		0, 0, -14, -12, -17, -57, -29, -147, -527, -1098,
		-1570, -1962, -2379, -2737, -3077, -3467, -3910, -3985, -4308, -5197,
		0, 0, 0, -19, -67, -31, -35, -285, -602, -1115,
		-1504, -1855, -2178, -2473, -2823, -3290, -3905, -3873, -4147, -5197,
		0, 0, 0, 0, -8, -33, -76, -268, -585, -989,
		-1333, -1657, -1989, -2293, -2569, -3172, -3757, -3849, -3971, -5197,
		0, 0, 0, -4, -8, -33, -63, -350, -772, -1054,
		-1350, -1614, -2010, -2267, -2562, -3033, -3609, -3842, -5197, -5197,
		0, 0, 0, 0, -13, -59, -228, -569, -880, -1184,
		-1484, -1822, -2075, -2459, -2692, -2922, -3461, -3842, -5197, -5197,
		0, 0, -9, -26, -132, -297, -558, -822, -985, -1194,
		-1479, -1788, -2025, -2683, -2844, -2907, -3314, -5197, -5197, -5197,
		0, 0, -11, -71, -503, -722, -676, -864, -1106, -1283,
		-1447, -1594, -1903, -2251, -2582, -2914, -5197, -5197, -5197, -5197};

	typedef struct packed {
		logic             load;
		logic             search;
		logic [IDX_W-1:0] k;
		logic             setup;
		logic             den;
		logic             mul;
		logic             acc;
		logic [1:0]       term;
		logic             dinit;
		logic             dstep;
		logic             finish;
	} cmd_t;

endpackage

### src/map_bilinear_interpolation_core.sv
// Two-axis ignition-offset map lookup. Each word in carries a manifold pressure
// (pascals) and an engine speed (unsigned Q7.8); each word out carries the bilinear
// blend of the four surrounding 20x20 map entries in signed Q8.8, rounded to nearest
// (ties away from zero), saturated, plus a flag set when either axis lay outside its
// breakpoint range (outside values extrapolate along the end interval). One word is
// processed at a time: breakpoint scan (one breakpoint of each axis per cycle),
// setup and span product, the four weighted taps on one shared multiplier pair, and
// restoring division. The result sits in an output register, so the next word is
// accepted while the previous result still waits for out_ready.
module map_bilinear_interpolation_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [mbi_pkg::ROW_W-1:0]           row_axis_value,
	input  logic [mbi_pkg::COL_W-1:0]           col_axis_value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [mbi_pkg::OUT_W-1:0]    map_output,
	output logic                                extrapolated
);

	mbi_pkg::cmd_t cmd;

	// sequence the search, tap accumulation and division
	mbi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// hold operands, breakpoint tables, map and arithmetic
	mbi_datapath u_datapath (
		.clk            (clk),
		.cmd            (cmd),
		.row_axis_value (row_axis_value),
		.col_axis_value (col_axis_value),
		.map_output     (map_output),
		.extrapolated   (extrapolated)
	);

endmodule

### src/mbi_ctrl.sv
module mbi_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output mbi_pkg::cmd_t cmd
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_SEARCH = 4'd1;
	localparam logic [3:0] ST_SETUP  = 4'd2;
	localparam logic [3:0] ST_DEN    = 4'd3;
	localparam logic [3:0] ST_MUL    = 4'd4;
	localparam logic [3:0] ST_ACC    = 4'd5;
	localparam logic [3:0] ST_DINIT  = 4'd6;
	localparam logic [3:0] ST_DIV    = 4'd7;
	localparam logic [3:0] ST_FIN    = 4'd8;

	localparam logic [mbi_pkg::IDX_W-1:0] K_LAST =
		mbi_pkg::IDX_W'(mbi_pkg::MAX_POINTS - 1);
	localparam logic [mbi_pkg::STEP_W-1:0] STEP_FIRST =
		mbi_pkg::STEP_W'(mbi_pkg::Q_W - 1);

	logic [3:0]                   state_q;
	logic [mbi_pkg::IDX_W-1:0]    k_q;
	logic [1:0]                   term_q;
	logic [mbi_pkg::STEP_W-1:0]   step_q;
	logic                         out_valid_q;
	logic                         fin_go;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign fin_go    = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	always_comb begin
		cmd        = '0;
		cmd.load   = in_valid && in_ready;
		cmd.search = (state_q == ST_SEARCH);
		cmd.k      = k_q;
		cmd.setup  = (state_q == ST_SETUP);
		cmd.den    = (state_q == ST_DEN);
		cmd.mul    = (state_q == ST_MUL);
		cmd.acc    = (state_q == ST_ACC);
		cmd.term   = term_q;
		cmd.dinit  = (state_q == ST_DINIT);
		cmd.dstep  = (state_q == ST_DIV);
		cmd.finish = fin_go;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			term_q      <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_go)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					k_q <= mbi_pkg::IDX_W'(1);
					if (in_valid)
						state_q <= ST_SEARCH;
				end
				ST_SEARCH: begin
					k_q <= k_q + 1'b1;
					if (k_q == K_LAST)
						state_q <= ST_SETUP;
				end
				ST_SETUP: state_q <= ST_DEN;
				ST_DEN: begin
					term_q  <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: state_q <= ST_ACC;
				ST_ACC: begin
					term_q <= term_q + 1'b1;
					if (term_q == 2'd3)
						state_q <= ST_DINIT;
					else
						state_q <= ST_MUL;
				end
				ST_DINIT: begin
					step_q  <= STEP_FIRST;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q - 1'b1;
					if (step_q == '0)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_go)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### src/mbi_datapath.sv
module mbi_datapath (
	input  logic                                clk,
	input  mbi_pkg::cmd_t                       cmd,
	input  logic [mbi_pkg::ROW_W-1:0]           row_axis_value,
	input  logic [mbi_pkg::COL_W-1:0]           col_axis_value,
	output logic signed [mbi_pkg::OUT_W-1:0]    map_output,
	output logic                                extrapolated
);

	localparam int ROW_W = mbi_pkg::ROW_W;
	localparam int COL_W = mbi_pkg::COL_W;
	localparam int IDX_W = mbi_pkg::IDX_W;
	localparam int RD_W  = mbi_pkg::RD_W;
	localparam int CD_W  = mbi_pkg::CD_W;
	localparam int ACC_W = mbi_pkg::ACC_W;
	localparam int REM_W = mbi_pkg::REM_W;
	localparam int DSH_W = mbi_pkg::DSH_W;
	localparam int DEN_W = mbi_pkg::DEN_W;
	localparam int Q_W   = mbi_pkg::Q_W;
	localparam int OUT_W = mbi_pkg::OUT_W;

	localparam logic [IDX_W-1:0] ROW_LAST = IDX_W'(mbi_pkg::ROW_POINTS - 1);
	localparam logic [IDX_W-1:0] COL_LAST = IDX_W'(mbi_pkg::COL_POINTS - 1);
	localparam logic [Q_W-1:0]   POS_MAX  = Q_W'((1 << (OUT_W - 1)) - 1);
	localparam logic [Q_W-1:0]   NEG_MAX  = Q_W'(1 << (OUT_W - 1));

	logic [ROW_W-1:0]                x_q;
	logic [COL_W-1:0]                c_q;
	logic [IDX_W-1:0]                ri_q, ci_q;
	logic                            rfound_q, cfound_q, ext_q;
	logic [ROW_W-1:0]                sr_q;
	logic [COL_W-1:0]                sc_q;
	logic signed [RD_W-1:0]          dr_q, wr0_q;
	logic signed [CD_W-1:0]          dc_q, wc0_q;
	logic [DEN_W-1:0]                den_q;
	logic signed [mbi_pkg::PROD_W-1:0] prod_q;
	logic signed [OUT_W-1:0]         map_q;
	logic signed [ACC_W-1:0]         acc_q;
	logic                            neg_q;
	logic [REM_W-1:0]                rem_q;
	logic [DSH_W-1:0]                dsh_q;
	logic [Q_W-1:0]                  quo_q;
	logic signed [OUT_W-1:0]         res_q;
	logic                            res_ext_q;

	logic [ROW_W-1:0]       rlo, rhi;
	logic [COL_W-1:0]       clo, chi;
	logic [IDX_W-1:0]       ridx, cidx;
	logic [mbi_pkg::MAP_AW-1:0] maddr;
	logic signed [RD_W-1:0] rsel;
	logic signed [CD_W-1:0] csel;
	logic [ACC_W-1:0]       mag;
	logic [REM_W-1:0]       dsh_ext;
	logic                   take;
	logic signed [OUT_W-1:0] sat_val;

	assign rlo  = mbi_pkg::ROW_BP[ri_q - 1'b1];
	assign rhi  = mbi_pkg::ROW_BP[ri_q];
	assign clo  = mbi_pkg::COL_BP[ci_q - 1'b1];
	assign chi  = mbi_pkg::COL_BP[ci_q];
	assign ridx = cmd.term[0] ? ri_q : ri_q - 1'b1;
	assign cidx = cmd.term[1] ? ci_q : ci_q - 1'b1;
	assign maddr = mbi_pkg::MAP_AW'(ridx * mbi_pkg::COL_POINTS + cidx);
	assign rsel = cmd.term[0] ? dr_q : wr0_q;
	assign csel = cmd.term[1] ? dc_q : wc0_q;
	assign mag  = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
	assign dsh_ext = REM_W'(dsh_q);
	assign take = rem_q >= dsh_ext;

	// round-half-away quotient, clamp to the Q8.8 range
	always_comb begin
		if (neg_q)
			sat_val = (quo_q > NEG_MAX) ? -OUT_W'(NEG_MAX) : OUT_W'(-quo_q);
		else
			sat_val = (quo_q > POS_MAX) ? OUT_W'(POS_MAX) : OUT_W'(quo_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q      <= row_axis_value;
			c_q      <= col_axis_value;
			ri_q     <= ROW_LAST;
			ci_q     <= COL_LAST;
			rfound_q <= 1'b0;
			cfound_q <= 1'b0;
			ext_q    <= (row_axis_value < mbi_pkg::ROW_BP[0])
				|| (row_axis_value > mbi_pkg::ROW_BP[mbi_pkg::ROW_POINTS-1])
				|| (col_axis_value < mbi_pkg::COL_BP[0])
				|| (col_axis_value > mbi_pkg::COL_BP[mbi_pkg::COL_POINTS-1]);
		end
		// first breakpoint above the value marks the upper index
		if (cmd.search) begin
			if (!rfound_q && cmd.k <= ROW_LAST && x_q < mbi_pkg::ROW_BP[cmd.k]) begin
				ri_q     <= cmd.k;
				rfound_q <= 1'b1;
			end
			if (!cfound_q && cmd.k <= COL_LAST && c_q < mbi_pkg::COL_BP[cmd.k]) begin
				ci_q     <= cmd.k;
				cfound_q <= 1'b1;
			end
		end
		if (cmd.setup) begin
			sr_q  <= rhi - rlo;
			sc_q  <= chi - clo;
			dr_q  <= $signed({1'b0, x_q}) - $signed({1'b0, rlo});
			wr0_q <= $signed({1'b0, rhi}) - $signed({1'b0, x_q});
			dc_q  <= $signed({1'b0, c_q}) - $signed({1'b0, clo});
			wc0_q <= $signed({1'b0, chi}) - $signed({1'b0, c_q});
			acc_q <= '0;
		end
		if (cmd.den)
			den_q <= DEN_W'(sr_q * sc_q);
		if (cmd.mul) begin
			prod_q <= mbi_pkg::PROD_W'(rsel * csel);
			map_q  <= mbi_pkg::OFFSET_MAP[maddr];
		end
		if (cmd.acc)
			acc_q <= acc_q + ACC_W'(prod_q * map_q);
		if (cmd.dinit) begin
			neg_q <= acc_q[ACC_W-1];
			rem_q <= {1'b0, mag, 1'b0} + REM_W'(den_q);
			dsh_q <= DSH_W'({den_q, 1'b0}) << (Q_W - 1);
			quo_q <= '0;
		end
		if (cmd.dstep) begin
			if (take)
				rem_q <= rem_q - dsh_ext;
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[Q_W-2:0], take};
		end
		if (cmd.finish) begin
			res_q     <= sat_val;
			res_ext_q <= ext_q;
		end
	end

	assign map_output   = res_q;
	assign extrapolated = res_ext_q;

endmodule

### bench/tb_map_bilinear_interpolation_core.sv
`timescale 1ns / 100ps

module tb_map_bilinear_interpolation_core;

	localparam int ROW_W      = mbi_pkg::ROW_W;
	localparam int COL_W      = mbi_pkg::COL_W;
	localparam int OUT_W      = mbi_pkg::OUT_W;
	localparam int ROW_POINTS = mbi_pkg::ROW_POINTS;
	localparam int COL_POINTS = mbi_pkg::COL_POINTS;
	localparam logic [ROW_W-1:0] ROW_BP [ROW_POINTS] = mbi_pkg::ROW_BP;
	localparam logic [COL_W-1:0] COL_BP [COL_POINTS] = mbi_pkg::COL_BP;
	localparam logic signed [OUT_W-1:0] OFFSET_MAP [mbi_pkg::MAP_DEPTH] =
		mbi_pkg::OFFSET_MAP;

	localparam int ITEM_COUNT = 1250;
	localparam longint CYCLE_LIMIT = 64'd400000;

	typedef struct packed {
		logic [ROW_W-1:0] pressure;
		logic [COL_W-1:0] speed;
	} lookup_word_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] offset;
		logic                    outside;
	} offset_word_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [ROW_W-1:0] row_axis_value;
	logic [COL_W-1:0] col_axis_value;
	logic out_valid;
	logic out_ready;
	logic signed [OUT_W-1:0] map_output;
	logic extrapolated;

	// Acceptance seen at the last rising edge, so the driver knows the word left.
	logic in_ready_seen;

	lookup_word_t pending_lookups[$];
	offset_word_t expected_offsets[$];

	// idle percentages for the sender and the receiver, changed per phase
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned mismatch_count;
	int unsigned accepted_count;
	longint cycle_count;
	bit stimulus_done;

	map_bilinear_interpolation_core DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.row_axis_value (row_axis_value),
		.col_axis_value (col_axis_value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.map_output     (map_output),
		.extrapolated   (extrapolated)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Find the upper breakpoint of the bracketing interval: the first k in
	// 1..n-1 with value below bp[k], held at n-1 past the last breakpoint.
	function automatic int pressure_upper(input logic [ROW_W-1:0] v);
		int k;
		k = 1;
		while (k < ROW_POINTS - 1 && v >= ROW_BP[k])
			k++;
		return k;
	endfunction

	function automatic int speed_upper(input logic [COL_W-1:0] v);
		int k;
		k = 1;
		while (k < COL_POINTS - 1 && v >= COL_BP[k])
			k++;
		return k;
	endfunction

	// Blend the four neighbors exactly, round half away from zero, saturate.
	function automatic offset_word_t interpolate_offset(input lookup_word_t w);
		int ri, ci;
		longint sr, sc, dr, dc, wr0, wc0, num, den, mag, q;
		offset_word_t r;
		ri  = pressure_upper(w.pressure);
		ci  = speed_upper(w.speed);
		sr  = longint'(ROW_BP[ri]) - longint'(ROW_BP[ri-1]);
		sc  = longint'(COL_BP[ci]) - longint'(COL_BP[ci-1]);
		dr  = longint'(w.pressure) - longint'(ROW_BP[ri-1]);
		dc  = longint'(w.speed) - longint'(COL_BP[ci-1]);
		wr0 = sr - dr;
		wc0 = sc - dc;
		num = wr0 * wc0 * longint'(OFFSET_MAP[(ri-1)*COL_POINTS + ci-1])
		    + dr * wc0 * longint'(OFFSET_MAP[ri*COL_POINTS + ci-1])
		    + wr0 * dc * longint'(OFFSET_MAP[(ri-1)*COL_POINTS + ci])
		    + dr * dc * longint'(OFFSET_MAP[ri*COL_POINTS + ci]);
		den = sr * sc;
		mag = (num < 0) ? -num : num;
		q   = (2 * mag + den) / (2 * den);
		if (num < 0)
			q = -q;
		if (q > 32767)
			q = 32767;
		if (q < -32768)
			q = -32768;
		r.offset  = q[OUT_W-1:0];
		r.outside = (w.pressure < ROW_BP[0]) || (w.pressure > ROW_BP[ROW_POINTS-1])
		         || (w.speed < COL_BP[0]) || (w.speed > COL_BP[COL_POINTS-1]);
		return r;
	endfunction

	function automatic void push_lookup(input int unsigned p, input int unsigned s);
		lookup_word_t w;
		w.pressure = p[ROW_W-1:0];
		w.speed    = s[COL_W-1:0];
		pending_lookups.push_back(w);
	endfunction

	// Pick an axis value: mostly inside the grid, sometimes on or next to a
	// breakpoint, sometimes anywhere across the full field width.
	function automatic int unsigned pick_pressure();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 60)
			return $urandom_range(ROW_BP[ROW_POINTS-1], ROW_BP[0]);
		else if (sel < 75)
			return ROW_BP[$urandom_range(ROW_POINTS-1)] + $urandom_range(2) - 1;
		return $urandom_range((1 << ROW_W) - 1);
	endfunction

	function automatic int unsigned pick_speed();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 60)
			return $urandom_range(COL_BP[COL_POINTS-1], COL_BP[0]);
		else if (sel < 75)
			return COL_BP[$urandom_range(COL_POINTS-1)] + $urandom_range(2) - 1;
		return $urandom_range((1 << COL_W) - 1);
	endfunction

	// Driver: present the next word at the falling edge; hold valid and the
	// payload until the word is taken.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid       <= 1'b0;
			row_axis_value <= '0;
			col_axis_value <= '0;
			out_ready      <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
			if (!in_valid || in_ready_seen) begin
				if (pending_lookups.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid       <= 1'b1;
					row_axis_value <= pending_lookups[0].pressure;
					col_axis_value <= pending_lookups[0].speed;
					pending_lookups.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: sample both handshakes at the rising edge, predict on input
	// acceptance, compare on output acceptance.
	always @(posedge clk or negedge arst_n) begin
		offset_word_t exp_w;
		lookup_word_t in_w;
		if (!arst_n) begin
			in_ready_seen <= 1'b0;
			cycle_count   <= 0;
		end else begin
			cycle_count   <= cycle_count + 1;
			in_ready_seen <= in_valid && in_ready;
			if (in_valid && in_ready) begin
				in_w.pressure = row_axis_value;
				in_w.speed    = col_axis_value;
				expected_offsets.push_back(interpolate_offset(in_w));
				accepted_count++;
			end
			if (out_valid && out_ready) begin
				if (expected_offsets.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected word: offset %0d outside %0b",
							map_output, extrapolated);
				end else begin
					exp_w = expected_offsets.pop_front();
					if (map_output !== exp_w.offset || extrapolated !== exp_w.outside) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("mismatch: expected offset %0d outside %0b, got %0d %0b",
								exp_w.offset, exp_w.outside, map_output, extrapolated);
					end
				end
			end
			if (cycle_count > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycle_count);
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		int unsigned target;
		int phase;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		mismatch_count = 0;
		accepted_count = 0;
		arst_n         = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: field extremes, end breakpoints, just outside and just inside
		// them, interior breakpoints, an interval midpoint and alternating bits.
		push_lookup(0, 0);
		push_lookup((1 << ROW_W) - 1, (1 << COL_W) - 1);
		push_lookup(0, (1 << COL_W) - 1);
		push_lookup((1 << ROW_W) - 1, 0);
		push_lookup(ROW_BP[0], COL_BP[0]);
		push_lookup(ROW_BP[ROW_POINTS-1], COL_BP[COL_POINTS-1]);
		push_lookup(ROW_BP[0] - 1, COL_BP[0]);
		push_lookup(ROW_BP[0], COL_BP[0] - 1);
		push_lookup(ROW_BP[ROW_POINTS-1] + 1, COL_BP[COL_POINTS-1]);
		push_lookup(ROW_BP[ROW_POINTS-1], COL_BP[COL_POINTS-1] + 1);
		push_lookup(ROW_BP[9], COL_BP[9]);
		push_lookup(ROW_BP[1], COL_BP[18]);
		push_lookup(ROW_BP[18], COL_BP[1]);
		push_lookup((ROW_BP[4] + ROW_BP[5]) / 2, (COL_BP[7] + COL_BP[8]) / 2);
		push_lookup(ROW_BP[0] + 1, COL_BP[COL_POINTS-1] - 1);
		push_lookup(18'h2AAAA, 15'h5555);
		push_lookup(18'h15555, 15'h2AAA);
		target = 17;

		// Phases: no idling, sender idle, receiver stalling, both.
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
				default: begin send_idle_pct = 33; recv_stall_pct = 33; end
			endcase
			repeat (ITEM_COUNT / 4)
				push_lookup(pick_pressure(), pick_speed());
			target += ITEM_COUNT / 4;
			wait (accepted_count == target);
		end

		wait (expected_offsets.size() == 0);
		repeat (100) @(posedge clk);
		if (mismatch_count == 0 && expected_offsets.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

### map_bilinear_interpolation_core.f
src/mbi_pkg.sv
src/mbi_ctrl.sv
src/mbi_datapath.sv
src/map_bilinear_interpolation_core.sv
bench/tb_map_bilinear_interpolation_core.sv
